[hdl/median_by_rank_count_defines.svh]
// Assertion macros used by the checker file.
`ifndef MEDIAN_BY_RANK_COUNT_DEFINES_SVH
`define MEDIAN_BY_RANK_COUNT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MBRC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mbrc check failed: same-cycle rule");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MBRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mbrc check failed: next-cycle rule");

`endif

[hdl/mbrc_pkg.sv]
package mbrc_pkg;

	// Input word: one value of the set, with the end-of-set mark
	typedef struct packed {
		logic [31:0] sample_value;
		logic        is_last;
	} in_word_t;

	// Result word: median of the set and its bookkeeping
	typedef struct packed {
		logic [31:0] median_value;
		logic [6:0]  values_used;
		logic        overflowed;
	} out_word_t;

	// Sequencer states
	typedef enum logic {
		ST_COLLECT,
		ST_SEEK
	} state_t;

	// Commands broadcast from the sequencer to every cell
	typedef struct packed {
		logic insert;
		logic shift;
		logic clear;
	} cell_cmd_t;

endpackage

[hdl/mbrc_cell.sv]
module mbrc_cell #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mbrc_pkg::cell_cmd_t    cmd,
	input  logic [VALUE_WIDTH-1:0] new_value,
	input  logic [VALUE_WIDTH-1:0] prev_value,
	input  logic                   prev_valid,
	input  logic                   prev_gt,
	input  logic [VALUE_WIDTH-1:0] next_value,
	input  logic                   next_valid,
	output logic [VALUE_WIDTH-1:0] value,
	output logic                   valid,
	output logic                   gt
);

	logic [VALUE_WIDTH-1:0] value_q;
	logic                   valid_q;
	logic                   take_prev;
	logic                   take_new;

	// Compare held value against the broadcast word; ties stay ahead
	assign gt        = valid_q && (value_q > new_value);
	assign take_prev = prev_valid && prev_gt;
	assign take_new  = prev_valid && !prev_gt && (!valid_q || gt);

	// Valid flag: set on insert or shift-in, drop on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.shift) begin
			valid_q <= next_valid;
		end else if (cmd.insert && (take_prev || take_new)) begin
			valid_q <= 1'b1;
		end
	end

	// Held value: move up on insert, move down toward the head on shift
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			value_q <= next_value;
		end else if (cmd.insert) begin
			if (take_prev) begin
				value_q <= prev_value;
			end else if (take_new) begin
				value_q <= new_value;
			end
		end
	end

	assign value = value_q;
	assign valid = valid_q;

endmodule

[hdl/mbrc_ctrl.sv]
module mbrc_ctrl #(
	parameter int MAX_COUNT   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   is_last,
	input  logic [VALUE_WIDTH-1:0] head_value,
	output logic                   busy,
	output mbrc_pkg::cell_cmd_t    cmd,
	output logic                   done,
	output mbrc_pkg::out_word_t    result
);

	localparam int CW = $clog2(MAX_COUNT + 1);

	mbrc_pkg::state_t       state_q, state_d;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          count_nx;
	logic [CW-1:0]          rem_q;
	logic [CW-1:0]          used_q;
	logic                   ovf_q;
	logic                   ovf_out_q;
	logic                   done_q;
	logic [VALUE_WIDTH-1:0] median_q;
	logic                   accept;
	logic                   full;

	assign full     = (count_q == CW'(MAX_COUNT));
	assign accept   = start && (state_q == mbrc_pkg::ST_COLLECT);
	assign count_nx = count_q + CW'(accept && !full);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mbrc_pkg::ST_COLLECT: begin
				if (accept && is_last) begin
					state_d = mbrc_pkg::ST_SEEK;
				end
			end
			mbrc_pkg::ST_SEEK: begin
				if (rem_q == '0) begin
					state_d = mbrc_pkg::ST_COLLECT;
				end
			end
			default: state_d = mbrc_pkg::ST_COLLECT;
		endcase
	end

	// Outputs and cell commands
	always_comb begin
		busy       = 1'b0;
		cmd.insert = 1'b0;
		cmd.shift  = 1'b0;
		cmd.clear  = 1'b0;
		case (state_q)
			mbrc_pkg::ST_COLLECT: begin
				cmd.insert = accept && !full;
			end
			mbrc_pkg::ST_SEEK: begin
				busy      = 1'b1;
				cmd.shift = (rem_q != '0);
				cmd.clear = (rem_q == '0);
			end
			default: busy = 1'b0;
		endcase
	end

	// Control registers: count, overflow, seek distance, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mbrc_pkg::ST_COLLECT;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			rem_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == mbrc_pkg::ST_SEEK) && (rem_q == '0);
			if (accept) begin
				if (is_last) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					rem_q   <= count_nx >> 1;
				end else begin
					count_q <= count_nx;
					ovf_q   <= ovf_q | full;
				end
			end else if (state_q == mbrc_pkg::ST_SEEK && rem_q != '0) begin
				rem_q <= rem_q - CW'(1);
			end
		end
	end

	// Result payload: capture set totals, then the head of the chain
	always_ff @(posedge clk) begin
		if (accept && is_last) begin
			used_q    <= count_nx;
			ovf_out_q <= ovf_q | full;
		end
		if (state_q == mbrc_pkg::ST_SEEK && rem_q == '0) begin
			median_q <= head_value;
		end
	end

	assign done                = done_q;
	assign result.median_value = 32'(median_q);
	assign result.values_used  = 7'(used_q);
	assign result.overflowed   = ovf_out_q;

endmodule

[hdl/median_by_rank_count.sv]
// Streaming median of a set of unsigned values.
// Input: a word (sample) is taken at a clock edge with start high and busy
// low. Each word carries one value; the word with is_last set closes the set.
// Output: done is high for exactly one cycle with the result word (median at
// rank count/2, count of kept values, overflow flag) valid in that cycle.
// There is no back-pressure on the result side.
// Timing: while a set is open, start may stay high and a new value enters
// on every edge. The closing word makes the block busy while the row walks
// toward the head; busy falls and done rises in the same cycle. A new set
// may start in the cycle that done is shown.
// Structure: a row of MAX_COUNT cells keeps values in ascending order; each
// new value is inserted by a compare in every cell and a shift
// by one toward the tail. At the end of a set the row shifts toward the head
// until the median sits in the first cell; that walk sets the busy time.
// Values past MAX_COUNT are dropped and flagged.
// Reset: arst_n clears the count, overflow flag, cell valid flags and strobe.
module median_by_rank_count #(
	parameter int MAX_COUNT   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mbrc_pkg::in_word_t  sample,
	output logic                done,
	output mbrc_pkg::out_word_t result
);

	mbrc_pkg::cell_cmd_t    cmd;
	logic [VALUE_WIDTH-1:0] new_value;
	logic [VALUE_WIDTH-1:0] cell_value [MAX_COUNT];
	logic                   cell_valid [MAX_COUNT];
	logic                   cell_gt    [MAX_COUNT];

	// Keep only the low VALUE_WIDTH bits of the incoming value
	assign new_value = VALUE_WIDTH'(sample.sample_value);

	mbrc_ctrl #(
		.MAX_COUNT  (MAX_COUNT),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.is_last   (sample.is_last),
		.head_value(cell_value[0]),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result)
	);

	// Row of sorting cells; head is cell 0
	for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] prev_value;
		logic                   prev_valid;
		logic                   prev_gt;
		logic [VALUE_WIDTH-1:0] next_value;
		logic                   next_valid;

		if (i == 0) begin : g_head
			assign prev_value = '0;
			assign prev_valid = 1'b1;
			assign prev_gt    = 1'b0;
		end else begin : g_body
			assign prev_value = cell_value[i-1];
			assign prev_valid = cell_valid[i-1];
			assign prev_gt    = cell_gt[i-1];
		end

		if (i == MAX_COUNT - 1) begin : g_tail
			assign next_value = '0;
			assign next_valid = 1'b0;
		end else begin : g_mid
			assign next_value = cell_value[i+1];
			assign next_valid = cell_valid[i+1];
		end

		mbrc_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.new_value (new_value),
			.prev_value(prev_value),
			.prev_valid(prev_valid),
			.prev_gt   (prev_gt),
			.next_value(next_value),
			.next_valid(next_valid),
			.value     (cell_value[i]),
			.valid     (cell_valid[i]),
			.gt        (cell_gt[i])
		);
	end

endmodule

[hdl/mbrc_checker.sv]
`include "median_by_rank_count_defines.svh"

module mbrc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input mbrc_pkg::in_word_t  sample,
	input logic                done,
	input mbrc_pkg::out_word_t result
);

	// Strobe only shows once the sequencer is free again
	`MBRC_ASSERT_NOW(a_done_not_busy, done, !busy)

	// A strobe never repeats in the following cycle
	`MBRC_ASSERT_NEXT(a_done_single, done, !done)

	// A word inside a set leaves the block free for the next one
	`MBRC_ASSERT_NEXT(a_mid_set_free, start && !busy && !sample.is_last, !busy)

	// The closing word always starts the median walk
	`MBRC_ASSERT_NEXT(a_last_busy, start && !busy && sample.is_last, busy)

	// Every reported set holds at least one value
	`MBRC_ASSERT_NOW(a_used_nonzero, done, result.values_used != 7'd0)

endmodule

bind median_by_rank_count mbrc_checker u_mbrc_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.sample(sample),
	.done  (done),
	.result(result)
);

[tb/sv/median_by_rank_count_tb.sv]
module median_by_rank_count_tb;

	localparam int unsigned MAX_KEPT    = 64;
	localparam int unsigned RAND_WORDS  = 480;
	localparam int unsigned TAIL_CYCLES = 60;
	localparam int unsigned REPORT_MAX  = 10;

	// One row of the opening table: the word to send and, where it is plain,
	// the result it must produce
	typedef struct packed {
		mbrc_pkg::in_word_t  w;
		logic                typed;
		mbrc_pkg::out_word_t want;
	} opening_row_t;

	localparam int unsigned OPEN_ROWS = 18;
	localparam opening_row_t OPENING [OPEN_ROWS] = '{
		// single-value sets at both extremes
		'{'{32'h0000_0000, 1'b1}, 1'b1, '{32'h0000_0000, 7'd1, 1'b0}},
		'{'{32'hFFFF_FFFF, 1'b1}, 1'b1, '{32'hFFFF_FFFF, 7'd1, 1'b0}},
		// even count picks the upper median
		'{'{32'd5, 1'b0}, 1'b0, '0},
		'{'{32'd3, 1'b1}, 1'b1, '{32'd5, 7'd2, 1'b0}},
		// ties kept in arrival order
		'{'{32'd7, 1'b0}, 1'b0, '0},
		'{'{32'd7, 1'b0}, 1'b0, '0},
		'{'{32'd1, 1'b1}, 1'b0, '0},
		// alternating bit patterns and extremes mixed
		'{'{32'hFFFF_FFFF, 1'b0}, 1'b0, '0},
		'{'{32'h0000_0000, 1'b0}, 1'b0, '0},
		'{'{32'hAAAA_AAAA, 1'b0}, 1'b0, '0},
		'{'{32'h5555_5555, 1'b1}, 1'b0, '0},
		// descending run, every value shifts the whole row
		'{'{32'd9, 1'b0}, 1'b0, '0},
		'{'{32'd8, 1'b0}, 1'b0, '0},
		'{'{32'd7, 1'b0}, 1'b0, '0},
		'{'{32'd6, 1'b0}, 1'b0, '0},
		'{'{32'd5, 1'b1}, 1'b0, '0},
		'{'{32'd1, 1'b0}, 1'b0, '0},
		'{'{32'd0, 1'b1}, 1'b1, '{32'd1, 7'd2, 1'b0}}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	mbrc_pkg::in_word_t  sample;
	logic                done;
	mbrc_pkg::out_word_t result;

	// Typed expectation travels beside the word that causes it
	logic                typed_on;
	mbrc_pkg::out_word_t typed_want;

	// Predictor state: the ranked row, its fill and the drop flag
	logic [31:0] ranked [MAX_KEPT];
	int unsigned kept;
	bit          dropped;

	mbrc_pkg::out_word_t medians_due [$];
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned words_sent;
	int unsigned sets_closed;
	int unsigned over_sets;

	median_by_rank_count DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sample (sample),
		.done   (done),
		.result (result)
	);

	always #1 clk = ~clk;

	// Give up after a generous fixed time
	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

	// Insert one word into the ranked row; on the closing word produce the median
	task automatic rank_word(input mbrc_pkg::in_word_t w, output bit closes,
			output mbrc_pkg::out_word_t med);
		int unsigned pos;
		med = '0;
		if (kept < MAX_KEPT) begin
			pos = kept;
			while (pos > 0 && ranked[pos - 1] > w.sample_value) begin
				ranked[pos] = ranked[pos - 1];
				pos--;
			end
			ranked[pos] = w.sample_value;
			kept++;
		end else begin
			dropped = 1'b1;
		end
		closes = w.is_last;
		if (w.is_last) begin
			med.median_value = ranked[kept / 2];
			med.values_used  = kept[6:0];
			med.overflowed   = dropped;
			kept    = 0;
			dropped = 1'b0;
		end
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (mismatches < REPORT_MAX)
			$display("mismatch %0s: expected %h, got %h", what, want, got);
		mismatches++;
	endtask

	// Check results against the oldest expectation, then predict accepted words
	always @(posedge clk) begin : monitor
		mbrc_pkg::out_word_t want;
		mbrc_pkg::out_word_t pred;
		bit                  closes;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (medians_due.size() == 0) begin
					note_mismatch("result with none due", 32'h0, result.median_value);
				end else begin
					want = medians_due.pop_front();
					if (result.median_value !== want.median_value)
						note_mismatch("median_value", want.median_value, result.median_value);
					if (result.values_used !== want.values_used)
						note_mismatch("values_used", 32'(want.values_used),
							32'(result.values_used));
					if (result.overflowed !== want.overflowed)
						note_mismatch("overflowed", 32'(want.overflowed),
							32'(result.overflowed));
				end
			end
			if (start && !busy) begin
				rank_word(sample, closes, pred);
				if (closes)
					medians_due.push_back(typed_on ? typed_want : pred);
			end
		end
	end

	// Present one word, idling first at the given rate, and hold it until taken
	task automatic send_word(input mbrc_pkg::in_word_t w, input logic typed,
			input mbrc_pkg::out_word_t want, input int unsigned idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		sample     <= w;
		typed_on   <= typed;
		typed_want <= want;
		do
			@(posedge clk);
		while (busy);
		words_sent++;
	endtask

	// Pick a value: extremes, a narrow range that makes ties, or anything
	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2, 3: return 32'($urandom_range(7));
			default: return $urandom;
		endcase
	endfunction

	task automatic send_set(input int unsigned n, input int unsigned idle_pct);
		mbrc_pkg::in_word_t w;
		for (int unsigned i = 0; i < n; i++) begin
			w.sample_value = pick_value();
			w.is_last      = (i == n - 1);
			send_word(w, 1'b0, '0, idle_pct);
		end
		sets_closed++;
		if (n > MAX_KEPT)
			over_sets++;
	endtask

	function automatic int unsigned pick_set_size();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 80)
			return $urandom_range(12, 1);
		else if (roll < 95)
			return $urandom_range(63, 13);
		return $urandom_range(72, 64);
	endfunction

	// Stop sending until every due result has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		wait (medians_due.size() == 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned idle_by_phase [4];
		int unsigned goal;
		idle_by_phase = '{0, 84, 0, 30};
		kept         = 0;
		dropped      = 1'b0;
		mismatches   = 0;
		results_seen = 0;
		words_sent   = 0;
		sets_closed  = 0;
		over_sets    = 0;
		arst_n     <= 1'b0;
		start      <= 1'b0;
		sample     <= '0;
		typed_on   <= 1'b0;
		typed_want <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the opening table back to back
		for (int unsigned r = 0; r < OPEN_ROWS; r++) begin
			send_word(OPENING[r].w, OPENING[r].typed, OPENING[r].want, 0);
			if (OPENING[r].w.is_last)
				sets_closed++;
		end
		drain();

		// Fill the row exactly, then overrun it by one and by two
		send_set(MAX_KEPT, 0);
		send_set(MAX_KEPT + 1, 0);
		send_set(MAX_KEPT + 2, 30);
		drain();

		// Random sets across the idling phases
		goal = words_sent;
		for (int ph = 0; ph < 4; ph++) begin
			goal += RAND_WORDS / 4;
			while (words_sent < goal)
				send_set(pick_set_size(), idle_by_phase[ph]);
			drain();
		end

		start <= 1'b0;
		wait (medians_due.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (medians_due.size() != 0)
			mismatches++;

		$display("sent %0d words in %0d sets, %0d of them past the %0d-value row",
			words_sent, sets_closed, over_sets, MAX_KEPT);
		$display("checked %0d medians, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
